FILE: hdl/ifs_chaos_game_point_top_assert.svh
// Assertion macros for the point generator RTL (included by icg_back)
`ifndef IFS_CHAOS_GAME_POINT_TOP_ASSERT_SVH
`define IFS_CHAOS_GAME_POINT_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define ICG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define ICG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/icg_pkg.sv
package icg_pkg;

   // Fixed formats
   localparam int NUM_MAPS        = 4;
   localparam int SCREEN_HEIGHT   = 528;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int POINT_FRAC_BITS = 16;
   localparam int START_X         = 160;

   localparam int COEF_W     = 16;
   localparam int POINT_W    = 32;
   localparam int SW_W       = 12;
   localparam int THR_W      = 8;
   localparam int MAP_W      = 2;
   localparam int PIX_W      = 16;
   localparam int RNG_W      = 32;
   localparam int LANE_REG_W = 64;
   localparam int THR_REG_W  = 32;
   localparam int OFFS_W     = COEF_W + SW_W + 1;

   // CSR port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Stream payloads
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - (2 * PIX_W + MAP_W);

   // Front-to-back queue
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Reset values
   localparam logic [LANE_REG_W-1:0] LANE_RESET    = '0;
   localparam logic [THR_REG_W-1:0]  THR_RESET     = 32'hFFFB_D4B3;
   localparam logic [SW_W-1:0]       SW_RESET      = 12'd320;
   localparam logic [RNG_W-1:0]      RNG_SEED      = 32'd1;
   localparam logic [POINT_W-1:0]    POINT_X_RESET = POINT_W'(START_X) << POINT_FRAC_BITS;
   localparam logic [POINT_W-1:0]    POINT_Y_RESET = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_XX         = 3'd0,
      CSR_COEF_YX         = 3'd1,
      CSR_COEF_XY         = 3'd2,
      CSR_COEF_YY         = 3'd3,
      CSR_SHIFT_X         = 3'd4,
      CSR_SHIFT_Y         = 3'd5,
      CSR_PROB_THRESHOLDS = 3'd6,
      CSR_SCREEN_WIDTH    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [LANE_REG_W-1:0] coef_xx;
      logic [LANE_REG_W-1:0] coef_yx;
      logic [LANE_REG_W-1:0] coef_xy;
      logic [LANE_REG_W-1:0] coef_yy;
      logic [LANE_REG_W-1:0] shift_x;
      logic [LANE_REG_W-1:0] shift_y;
      logic [THR_REG_W-1:0]  prob_thresholds;
      logic [SW_W-1:0]       screen_width;
   } cfg_type;

   // One classified step: selected map lanes, offsets pre-scaled by width
   typedef struct packed {
      logic signed [COEF_W-1:0] gain_xx;
      logic signed [COEF_W-1:0] gain_yx;
      logic signed [COEF_W-1:0] gain_xy;
      logic signed [COEF_W-1:0] gain_yy;
      logic signed [OFFS_W-1:0] offs_x;
      logic signed [OFFS_W-1:0] offs_y;
      logic [MAP_W-1:0]         map_index;
   } entry_type;

   // Queue status toward the back end
   typedef struct packed {
      logic valid;
   } q_ctl_type;

   // Signed 16-bit lane k of a packed register
   function automatic logic signed [COEF_W-1:0] lane16(
      input logic [LANE_REG_W-1:0] word,
      input logic [MAP_W-1:0]      k
   );
      lane16 = $signed(word[k * COEF_W +: COEF_W]);
   endfunction

endpackage

FILE: hdl/icg_front.sv
module icg_front (
   input  logic                              clock,
   input  logic                              reset,
   input  icg_pkg::cfg_type                  cfg,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [icg_pkg::REQ_DATA_W-1:0]    req_tdata,   // [0] restart
   input  logic                              q_full,
   output logic                              push,
   output icg_pkg::entry_type                push_entry
);
   import icg_pkg::*;

   logic [RNG_W-1:0]  rng_ff;
   logic [RNG_W-1:0]  rng_in;
   logic [RNG_W-1:0]  seed;
   logic [RNG_W-1:0]  mix1;
   logic [RNG_W-1:0]  mix2;
   logic [RNG_W-1:0]  rng_next;
   logic [THR_W-1:0]  pick;
   logic [MAP_W-1:0]  sel;
   logic              found;
   logic signed [SW_W:0] width_s;

   // Take an item whenever the queue has room
   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;

   // xorshift32 step, optional reseed first
   assign seed     = req_tdata[0] ? RNG_SEED : rng_ff;
   assign mix1     = seed ^ (seed << 13);
   assign mix2     = mix1 ^ (mix1 >> 17);
   assign rng_next = mix2 ^ (mix2 << 5);
   assign pick     = rng_next[THR_W-1:0];
   assign rng_in   = push ? rng_next : rng_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_ff <= RNG_SEED;
      end else begin
         rng_ff <= rng_in;
      end
   end

   // First map whose cumulative threshold covers the byte; last map otherwise
   always_comb begin
      sel   = MAP_W'(NUM_MAPS - 1);
      found = 1'b0;
      for (int i = 0; i < NUM_MAPS - 1; i++) begin
         if (!found && (pick <= cfg.prob_thresholds[i * THR_W +: THR_W])) begin
            sel   = MAP_W'(i);
            found = 1'b1;
         end
      end
   end

   // Fetch the selected lanes and scale offsets by screen width
   assign width_s = $signed({1'b0, cfg.screen_width});

   always_comb begin
      push_entry.gain_xx   = lane16(cfg.coef_xx, sel);
      push_entry.gain_yx   = lane16(cfg.coef_yx, sel);
      push_entry.gain_xy   = lane16(cfg.coef_xy, sel);
      push_entry.gain_yy   = lane16(cfg.coef_yy, sel);
      push_entry.offs_x    = lane16(cfg.shift_x, sel) * width_s;
      push_entry.offs_y    = lane16(cfg.shift_y, sel) * width_s;
      push_entry.map_index = sel;
   end

endmodule

FILE: hdl/icg_queue.sv
module icg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  icg_pkg::entry_type   push_entry,
   output logic                 full,
   output icg_pkg::q_ctl_type   q_ctl_out,
   input  logic                 pop,
   output icg_pkg::entry_type   head_entry
);
   import icg_pkg::*;

   entry_type         mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_in;
   logic [Q_CNT_W-1:0] cnt_ff;
   logic [Q_CNT_W-1:0] cnt_in;

   function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
      ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full            = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign q_ctl_out.valid = (cnt_ff != '0);
   assign head_entry      = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hdl/icg_back.sv
`include "ifs_chaos_game_point_top_assert.svh"

module icg_back (
   input  logic                            clock,
   input  logic                            reset,
   input  icg_pkg::q_ctl_type              q_ctl_in,
   input  icg_pkg::entry_type              head_entry,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [icg_pkg::RSP_DATA_W-1:0]  rsp_tdata   // [15:0] pixel_x, [31:16] pixel_y,
                                                       // [33:32] map_index
);
   import icg_pkg::*;

   localparam int ACC_W = COEF_W + POINT_W + 4;
   localparam int FR    = POINT_FRAC_BITS;
   localparam logic signed [POINT_W:0] HEIGHT_S = (POINT_W + 1)'(SCREEN_HEIGHT);

   // Point stage (holds the architectural point) and output register
   logic                      a_valid_ff;
   logic                      a_valid_in;
   logic [MAP_W-1:0]          a_map_ff;
   logic signed [POINT_W-1:0] point_x_ff;
   logic signed [POINT_W-1:0] point_y_ff;
   logic signed [POINT_W-1:0] point_x_in;
   logic signed [POINT_W-1:0] point_y_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [PIX_W-1:0]          rsp_x_ff;
   logic [PIX_W-1:0]          rsp_y_ff;
   logic [MAP_W-1:0]          rsp_map_ff;
   logic                      out_free;

   logic signed [ACC_W-1:0]   acc_x;
   logic signed [ACC_W-1:0]   acc_y;
   logic signed [POINT_W-1:0] biased_x;
   logic signed [POINT_W-1:0] biased_y;
   logic signed [POINT_W:0]   int_x;
   logic signed [POINT_W:0]   int_y;
   logic [PIX_W-1:0]          pix_x;
   logic [PIX_W-1:0]          pix_y;

   // Floor by 2^COEF_FRAC_BITS, then clamp to 32 bits
   function automatic logic [POINT_W-1:0] sat_point(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] s;
      logic                    ovf;
      s   = v >>> COEF_FRAC_BITS;
      ovf = !((&s[ACC_W-1:POINT_W-1]) || !(|s[ACC_W-1:POINT_W-1]));
      if (ovf) begin
         sat_point = s[ACC_W-1] ? {1'b1, {(POINT_W-1){1'b0}}} : {1'b0, {(POINT_W-1){1'b1}}};
      end else begin
         sat_point = s[POINT_W-1:0];
      end
   endfunction

   // Clamp to the pixel range
   function automatic logic [PIX_W-1:0] sat_pix(input logic signed [POINT_W:0] v);
      logic ovf;
      ovf = !((&v[POINT_W:PIX_W-1]) || !(|v[POINT_W:PIX_W-1]));
      if (ovf) begin
         sat_pix = v[POINT_W] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
      end else begin
         sat_pix = v[PIX_W-1:0];
      end
   endfunction

   // Handshake between queue, point stage and output register
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign pop          = q_ctl_in.valid && (!a_valid_ff || out_free);
   assign a_valid_in   = pop || (a_valid_ff && !out_free);
   assign rsp_valid_in = out_free ? a_valid_ff : rsp_valid_ff;

   // Affine map on the current point
   assign acc_x = head_entry.gain_xx * point_x_ff + head_entry.gain_yx * point_y_ff
                + (head_entry.offs_x <<< FR);
   assign acc_y = head_entry.gain_xy * point_x_ff + head_entry.gain_yy * point_y_ff
                + (head_entry.offs_y <<< FR);
   assign point_x_in = pop ? $signed(sat_point(acc_x)) : point_x_ff;
   assign point_y_in = pop ? $signed(sat_point(acc_y)) : point_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         point_x_ff   <= POINT_X_RESET;
         point_y_ff   <= POINT_Y_RESET;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         point_x_ff   <= point_x_in;
         point_y_ff   <= point_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_map_ff <= head_entry.map_index;
      end
   end

   // Truncate toward zero: bias negatives by 2^FR - 1 before the shift
   assign biased_x = point_x_ff
                   + $signed({{(POINT_W-FR){1'b0}}, {FR{point_x_ff[POINT_W-1]}}});
   assign biased_y = point_y_ff
                   + $signed({{(POINT_W-FR){1'b0}}, {FR{point_y_ff[POINT_W-1]}}});
   assign int_x    = biased_x >>> FR;
   assign int_y    = HEIGHT_S - (POINT_W + 1)'(biased_y >>> FR);
   assign pix_x    = sat_pix(int_x);
   assign pix_y    = sat_pix(int_y);

   // Output register
   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_x_ff   <= pix_x;
         rsp_y_ff   <= pix_y;
         rsp_map_ff <= a_map_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_map_ff, rsp_y_ff, rsp_x_ff};

   `ICG_ASSERT_NEXT(a_pop_lands, clock, reset, pop, a_valid_ff,
      "queue pop did not land in the point stage")
   `ICG_ASSERT_NEXT(a_hold_on_stall, clock, reset,
      a_valid_ff && rsp_valid_ff && !rsp_tready, $stable(point_x_ff) && $stable(point_y_ff),
      "point changed while the output was stalled")
   `ICG_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(a_valid_ff),
      "result appeared without a point in flight")

endmodule

FILE: hdl/ifs_chaos_game_point_top.sv
// Chaos-game point generator, one result per request.
// Requests pass the queue, the point stage and the output register in turn.
// One transfer per cycle while rsp_tready keeps up; the point update (four 16x32
// products, add, floor, clamp) is combinational; a 2-entry queue decouples sides.
// Reset (synchronous, active high): registers to defaults, generator to 1,
// point to (160, 0), queue and output emptied.
module ifs_chaos_game_point_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [icg_pkg::REQ_DATA_W-1:0]    req_tdata,   // [0] restart
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [icg_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [15:0] pixel_x, [31:16] pixel_y,
                                                          // [33:32] map_index
   input  logic                              csr_we,
   input  logic [icg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [icg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import icg_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      q_full;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head_entry;
   q_ctl_type q_ctl;

   // Configuration register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_XX:         cfg_in.coef_xx         = csr_wdata;
            CSR_COEF_YX:         cfg_in.coef_yx         = csr_wdata;
            CSR_COEF_XY:         cfg_in.coef_xy         = csr_wdata;
            CSR_COEF_YY:         cfg_in.coef_yy         = csr_wdata;
            CSR_SHIFT_X:         cfg_in.shift_x         = csr_wdata;
            CSR_SHIFT_Y:         cfg_in.shift_y         = csr_wdata;
            CSR_PROB_THRESHOLDS: cfg_in.prob_thresholds = csr_wdata[THR_REG_W-1:0];
            CSR_SCREEN_WIDTH:    cfg_in.screen_width    = csr_wdata[SW_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_xx         <= LANE_RESET;
         cfg_ff.coef_yx         <= LANE_RESET;
         cfg_ff.coef_xy         <= LANE_RESET;
         cfg_ff.coef_yy         <= LANE_RESET;
         cfg_ff.shift_x         <= LANE_RESET;
         cfg_ff.shift_y         <= LANE_RESET;
         cfg_ff.prob_thresholds <= THR_RESET;
         cfg_ff.screen_width    <= SW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: generator and map selection
   icg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue between front and back
   icg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .q_ctl_out  (q_ctl),
      .pop        (pop),
      .head_entry (head_entry)
   );

   // Back: point update and pixel output
   icg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_ctl_in   (q_ctl),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: tb/ifs_chaos_game_point_top_tb.sv
module ifs_chaos_game_point_top_tb;
   import icg_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT  = 10;

   // Result fields, pixel_x in the low bits as on rsp_tdata
   typedef struct packed {
      logic [MAP_W-1:0]        map_index;
      logic signed [PIX_W-1:0] pixel_y;
      logic signed [PIX_W-1:0] pixel_x;
   } pixel_result_type;

   // Tracks generator, point and registers; holds the pixels still owed
   class chaos_point_tracker;
      cfg_type                 cfg;
      logic [RNG_W-1:0]        rng;
      int                      pt_x;
      int                      pt_y;
      pixel_result_type        owed_pixels[$];
      int                      failures;

      function new();
         cfg.coef_xx         = LANE_RESET;
         cfg.coef_yx         = LANE_RESET;
         cfg.coef_xy         = LANE_RESET;
         cfg.coef_yy         = LANE_RESET;
         cfg.shift_x         = LANE_RESET;
         cfg.shift_y         = LANE_RESET;
         cfg.prob_thresholds = THR_RESET;
         cfg.screen_width    = SW_RESET;
         rng                 = RNG_SEED;
         pt_x                = int'(POINT_X_RESET);
         pt_y                = int'(POINT_Y_RESET);
         failures            = 0;
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function shortint lane(logic [LANE_REG_W-1:0] w, int s);
         return shortint'(w[COEF_W*s +: COEF_W]);
      endfunction

      // gx*x + gy*y + off*width, floored back to point format and clamped
      function int affine_coord(logic [LANE_REG_W-1:0] gx, logic [LANE_REG_W-1:0] gy,
                                logic [LANE_REG_W-1:0] off, int s);
         longint acc;
         acc = longint'(lane(gx, s)) * longint'(pt_x)
             + longint'(lane(gy, s)) * longint'(pt_y)
             + ((longint'(lane(off, s)) * longint'(cfg.screen_width)) <<< POINT_FRAC_BITS);
         acc = acc >>> COEF_FRAC_BITS;
         return int'(clamp(acc, -(longint'(1) << 31), (longint'(1) << 31) - 1));
      endfunction

      // One accepted request: advance generator, pick map, move the point
      function void note_step(bit restart);
         logic [7:0]       r;
         int               s;
         int               nx;
         int               ny;
         longint           qx;
         longint           qy;
         pixel_result_type want;
         if (restart) rng = RNG_SEED;
         rng ^= rng << 13;
         rng ^= rng >> 17;
         rng ^= rng << 5;
         r = rng[7:0];
         s = 0;
         while (s < NUM_MAPS - 1 && r > cfg.prob_thresholds[THR_W*s +: THR_W]) s++;
         nx = affine_coord(cfg.coef_xx, cfg.coef_yx, cfg.shift_x, s);
         ny = affine_coord(cfg.coef_xy, cfg.coef_yy, cfg.shift_y, s);
         pt_x = nx;
         pt_y = ny;
         // integer division truncates toward zero
         qx = longint'(nx) / (longint'(1) << POINT_FRAC_BITS);
         qy = longint'(ny) / (longint'(1) << POINT_FRAC_BITS);
         want.pixel_x   = PIX_W'(clamp(qx, -32768, 32767));
         want.pixel_y   = PIX_W'(clamp(longint'(SCREEN_HEIGHT) - qy, -32768, 32767));
         want.map_index = MAP_W'(s);
         owed_pixels.push_back(want);
      endfunction

      function void check_pixel(logic [RSP_DATA_W-1:0] d);
         pixel_result_type got;
         pixel_result_type want;
         got = d[$bits(pixel_result_type)-1:0];
         if (owed_pixels.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("[%0t] unexpected result x=%0d y=%0d map=%0d", $realtime,
                        got.pixel_x, got.pixel_y, got.map_index);
            return;
         end
         want = owed_pixels.pop_front();
         if (got != want) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("[%0t] mismatch: expected x=%0d y=%0d map=%0d, got x=%0d y=%0d map=%0d",
                        $realtime, want.pixel_x, want.pixel_y, want.map_index,
                        got.pixel_x, got.pixel_y, got.map_index);
         end
      endfunction

      function int owed();
         return owed_pixels.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;   // [0] restart
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;         // [15:0] pixel_x, [31:16] pixel_y, [33:32] map
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   chaos_point_tracker      tracker;
   int                      req_gap_pct   = 29;
   int                      rsp_stall_pct = 29;
   int                      cycle_count   = 0;

   ifs_chaos_game_point_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Transfer monitor and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_pixel(rsp_tdata);
         if (req_tvalid && req_tready) tracker.note_step(req_tdata[0]);
      end
   end

   // Four signed lanes, map 0 lowest
   function automatic logic [LANE_REG_W-1:0] lanes4(int a, int b, int c, int d);
      return {16'(d), 16'(c), 16'(b), 16'(a)};
   endfunction

   function automatic logic [LANE_REG_W-1:0] random_lanes(int mode);
      logic [LANE_REG_W-1:0] w;
      logic [15:0]           corner[5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h4000, 16'hC000};
      for (int k = 0; k < 4; k++) begin
         case (mode)
            0:       w[16*k +: 16] = 16'($urandom_range(24000)) - 16'd12000;
            1:       w[16*k +: 16] = 16'($urandom);
            default: w[16*k +: 16] = corner[$urandom_range(4)];
         endcase
      end
      return w;
   endfunction

   function automatic logic [THR_REG_W-1:0] random_thresholds();
      logic [7:0] t[4];
      case ($urandom_range(5))
         0: return THR_RESET;
         1: return 32'h0000_0000;
         2: return 32'hFFFF_FFFF;
         3: return $urandom;
         default: begin
            // ascending cumulative bytes
            t[0] = 8'($urandom_range(255));
            for (int k = 1; k < 4; k++) t[k] = t[k-1] + 8'($urandom_range(255 - t[k-1]));
            return {t[3], t[2], t[1], t[0]};
         end
      endcase
   endfunction

   function automatic logic [SW_W-1:0] random_width();
      case ($urandom_range(6))
         0:       return 12'd0;
         1:       return 12'd1;
         2:       return 12'd4095;
         3:       return SW_RESET;
         default: return 12'($urandom_range(4095, 1));
      endcase
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      int      gmode;
      gmode = ($urandom_range(9) < 6) ? 0 : $urandom_range(2, 1);
      c.coef_xx         = random_lanes(gmode);
      c.coef_yx         = random_lanes(gmode);
      c.coef_xy         = random_lanes(gmode);
      c.coef_yy         = random_lanes(gmode);
      c.shift_x         = random_lanes(gmode);
      c.shift_y         = random_lanes(gmode);
      c.prob_thresholds = random_thresholds();
      c.screen_width    = random_width();
      return c;
   endfunction

   // Write every register, junk in the unused upper bits of the narrow ones
   task automatic load_config(input cfg_type c);
      logic [CSR_DATA_W-1:0] vals[8];
      vals[CSR_COEF_XX]         = c.coef_xx;
      vals[CSR_COEF_YX]         = c.coef_yx;
      vals[CSR_COEF_XY]         = c.coef_xy;
      vals[CSR_COEF_YY]         = c.coef_yy;
      vals[CSR_SHIFT_X]         = c.shift_x;
      vals[CSR_SHIFT_Y]         = c.shift_y;
      vals[CSR_PROB_THRESHOLDS] = {32'($urandom), c.prob_thresholds};
      vals[CSR_SCREEN_WIDTH]    = {32'($urandom), 20'($urandom), c.screen_width};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      tracker.cfg = c;
   endtask

   // One request transfer; tvalid stays high unless a gap is taken
   task automatic send_request(input bit restart);
      if ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, restart};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold the sender until every owed pixel has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (tracker.owed() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      cfg_type c;
      int      n;
      int      pause_at;
      int      phase;
      int      sent;
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: zero gains collapse the point to the offsets
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);

      // Fern-like contracting maps, with a restart midway
      wait_idle();
      c.coef_xx         = lanes4(0, 13926, 3277, -2458);
      c.coef_yx         = lanes4(0, 655, -4260, 4588);
      c.coef_xy         = lanes4(0, -655, 3768, 4260);
      c.coef_yy         = lanes4(2621, 13926, 3604, 3932);
      c.shift_x         = lanes4(4096, 4096, 4096, 4096);
      c.shift_y         = lanes4(0, 819, 819, 205);
      c.prob_thresholds = THR_RESET;
      c.screen_width    = SW_RESET;
      load_config(c);
      for (int i = 0; i < 8; i++) send_request(i == 3);

      // Largest gains and offsets: point and pixel clamp high
      wait_idle();
      c.coef_xx = {4{16'h7FFF}};
      c.coef_yx = {4{16'h7FFF}};
      c.coef_xy = {4{16'h7FFF}};
      c.coef_yy = {4{16'h7FFF}};
      c.shift_x = {4{16'h7FFF}};
      c.shift_y = {4{16'h7FFF}};
      c.screen_width = 12'd4095;
      load_config(c);
      for (int i = 0; i < 5; i++) send_request(1'b0);

      // Most negative gains and offsets: clamp low, pixel_y clamps high
      wait_idle();
      c.coef_xx = {4{16'h8000}};
      c.coef_yx = {4{16'h8000}};
      c.coef_xy = {4{16'h8000}};
      c.coef_yy = {4{16'h8000}};
      c.shift_x = {4{16'h8000}};
      c.shift_y = {4{16'h8000}};
      load_config(c);
      for (int i = 0; i < 4; i++) send_request(1'b0);

      // Byte above all thresholds picks the last map; zero width kills offsets
      wait_idle();
      c.coef_xx         = lanes4(8192, -8192, 16384, -16384);
      c.coef_yy         = lanes4(-8192, 8192, 4096, 12000);
      c.prob_thresholds = 32'h0000_0000;
      c.screen_width    = 12'd0;
      load_config(c);
      for (int i = 0; i < 3; i++) send_request(i == 1);

      // Thresholds out of order: first lane at or above the byte still wins
      wait_idle();
      c.prob_thresholds = 32'h10FF_2080;
      c.screen_width    = 12'd1;
      load_config(c);
      for (int i = 0; i < 2; i++) send_request(1'b0);

      // Random phases, one of them without request gaps or output stalls
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         req_gap_pct   = (phase == 2) ? 0 : 29;
         rsp_stall_pct = (phase == 2) ? 0 : 29;
         load_config(random_cfg());
         n        = (phase == 2) ? 300 : $urandom_range(200, 40);
         if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
         pause_at = $urandom_range(n - 1, 1);
         for (int i = 0; i < n; i++) begin
            if (i == pause_at) wait_idle();
            send_request($urandom_range(15) == 0);
            sent++;
         end
         phase++;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (tracker.failures == 0 && tracker.owed() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
